// ----- rtl/core/assert_macros.svh -----
// assertion macros for rtl files that check themselves; the search top is the only user
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in this cycle implies a property in the same cycle
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");

// condition in this cycle implies a property in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/hcs_pkg.sv -----
// shared widths and defaults of the hamiltonian circuit search block
// no dependencies
package hcs_pkg;

   localparam int unsigned DEFAULT_NUM_VERTICES = 8;

   // fixed payload widths of the two channels
   localparam int unsigned ROW_INDEX_W = 3;
   localparam int unsigned ROW_EDGES_W = 8;
   localparam int unsigned VERTEX_W    = 3;

endpackage

// ----- rtl/core/hcs_req_if.sv -----
// request channel: one adjacency row per transfer
// depends on hcs_pkg
interface hcs_req_if;
   import hcs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ROW_INDEX_W-1:0] row_index;
   logic [ROW_EDGES_W-1:0] row_edges;
   logic                   last_row;

   modport source (output valid, row_index, row_edges, last_row, input ready);
   modport sink   (input valid, row_index, row_edges, last_row, output ready);
endinterface

// ----- rtl/core/hcs_rsp_if.sv -----
// response channel: one circuit vertex or a not-found flag per transfer
// depends on hcs_pkg
interface hcs_rsp_if;
   import hcs_pkg::*;

   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] vertex;
   logic                found;
   logic                last;

   modport source (output valid, vertex, found, last, input ready);
   modport sink   (input valid, vertex, found, last, output ready);
endinterface

// ----- rtl/core/hamiltonian_cycle_search_top.sv -----
// hamiltonian circuit search: row loads, backtracking search sequencer, result stage
// uses hcs_pkg, hcs_req_if, hcs_rsp_if, hcs_adj_mem, hcs_stack_mem, assert_macros.svh
// rate: one row load per cycle while idle; the search tests one candidate per cycle,
// an advance adds a row fetch (S_LOAD), a backtrack the end test, stack and row reads;
// results leave by alternate stack read and write states, waiting on a full result
// register; one stack read port; sync reset clears control state and row valid bits
`include "assert_macros.svh"

module hamiltonian_cycle_search_top #(
   parameter int unsigned NUM_VERTICES = hcs_pkg::DEFAULT_NUM_VERTICES
) (
   input  logic      clock,
   input  logic      reset,
   hcs_req_if.sink   req_bus,
   hcs_rsp_if.source rsp_bus
);
   import hcs_pkg::*;

   // vertex number width and a width that also holds NUM_VERTICES itself
   localparam int unsigned VW = $clog2(NUM_VERTICES);
   localparam int unsigned CW = $clog2(NUM_VERTICES + 1);
   // stack entry: {vertex, next candidate}
   localparam int unsigned SW = VW + CW;

   localparam logic [CW-1:0] N_C        = CW'(NUM_VERTICES);
   localparam logic [CW-1:0] LAST_DEPTH = CW'(NUM_VERTICES - 1);
   localparam logic [CW-1:0] ONE_C      = CW'(1);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INIT    = 4'd1;
   localparam logic [3:0] S_LOAD    = 4'd2;
   localparam logic [3:0] S_SCAN    = 4'd3;
   localparam logic [3:0] S_CHECK   = 4'd4;
   localparam logic [3:0] S_POP1    = 4'd5;
   localparam logic [3:0] S_POP2    = 4'd6;
   localparam logic [3:0] S_POP3    = 4'd7;
   localparam logic [3:0] S_EMIT_RD = 4'd8;
   localparam logic [3:0] S_EMIT_WR = 4'd9;
   localparam logic [3:0] S_NONE    = 4'd10;

   logic [3:0]              state_ff, state_in;
   logic [CW-1:0]           depth_ff, depth_in;
   logic [CW-1:0]           cand_ff, cand_in;
   logic [NUM_VERTICES-1:0] visited_ff, visited_in;
   logic [NUM_VERTICES-1:0] row_ff, row_in;
   logic [CW-1:0]           emit_ff, emit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_last_ff, rsp_last_in;

   // adjacency store ports
   logic                    adj_we;
   logic [VW-1:0]           adj_waddr;
   logic [NUM_VERTICES-1:0] adj_wdata;
   logic [VW-1:0]           adj_raddr;
   logic [NUM_VERTICES-1:0] adj_rdata;

   // path stack ports
   logic          stk_we;
   logic [VW-1:0] stk_waddr;
   logic [SW-1:0] stk_wdata;
   logic [VW-1:0] stk_raddr;
   logic [SW-1:0] stk_rdata;
   logic [VW-1:0] stk_vertex;
   logic [CW-1:0] stk_cand;

   logic                    req_transfer;
   logic                    row_in_range;
   logic [31:0]             row_index_ext;
   logic [31:0]             row_edges_ext;
   logic [31:0]             out_vertex_ext;
   logic                    out_free;
   logic [VW-1:0]           cand_vtx;
   logic                    cand_done;
   logic                    cand_ok;
   logic [NUM_VERTICES-1:0] cand_onehot;
   logic [NUM_VERTICES-1:0] pop_onehot;
   logic [CW-1:0]           cand_inc;
   logic [CW-1:0]           depth_dec;

   // ---------------------------------------------------------------- row loads
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_transfer  = req_bus.valid && req_bus.ready;

   // rows beyond the vertex count are dropped, edge bits beyond it are cut off
   assign row_index_ext = 32'(req_bus.row_index);
   assign row_edges_ext = 32'(req_bus.row_edges);
   assign row_in_range  = (row_index_ext < NUM_VERTICES);
   assign adj_we        = req_transfer && row_in_range;
   assign adj_waddr     = row_index_ext[VW-1:0];
   assign adj_wdata     = row_edges_ext[NUM_VERTICES-1:0];

   // ---------------------------------------------------------------- candidate test
   assign stk_vertex  = stk_rdata[SW-1:CW];
   assign stk_cand    = stk_rdata[CW-1:0];
   assign cand_vtx    = cand_ff[VW-1:0];
   assign cand_done   = (cand_ff >= N_C);
   // a candidate must be a neighbor of the previous vertex and not on the path yet
   assign cand_ok     = !cand_done && row_ff[cand_vtx] && !visited_ff[cand_vtx];
   assign cand_onehot = {{(NUM_VERTICES-1){1'b0}}, 1'b1} << cand_vtx;
   assign pop_onehot  = {{(NUM_VERTICES-1){1'b0}}, 1'b1} << stk_vertex;
   assign cand_inc    = cand_ff + ONE_C;
   assign depth_dec   = depth_ff - ONE_C;

   // the result register is free when empty or being drained this cycle
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign out_vertex_ext = 32'(stk_vertex);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      cand_in       = cand_ff;
      visited_in    = visited_ff;
      row_in        = row_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      adj_raddr     = '0;
      stk_we        = 1'b0;
      stk_waddr     = depth_ff[VW-1:0];
      stk_wdata     = {cand_vtx, cand_inc};
      stk_raddr     = depth_ff[VW-1:0];

      case (state_ff)
         S_IDLE: begin
            // the row lands in the store at this edge, the search starts after it
            if (req_transfer && req_bus.last_row) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            // path starts at vertex 0, first free depth is 1
            stk_we     = 1'b1;
            stk_waddr  = '0;
            stk_wdata  = {{VW{1'b0}}, ONE_C};
            visited_in = {{(NUM_VERTICES-1){1'b0}}, 1'b1};
            depth_in   = ONE_C;
            cand_in    = ONE_C;
            adj_raddr  = '0;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            // neighbor row of the vertex at depth-1
            row_in   = adj_rdata;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cand_done) begin
               // depth exhausted: step back, or give up at depth 1
               if (depth_ff == ONE_C) begin
                  state_in = S_NONE;
               end else begin
                  depth_in = depth_dec;
                  state_in = S_POP1;
               end
            end else if (cand_ok) begin
               // push the candidate and remember where to resume at this depth
               stk_we     = 1'b1;
               visited_in = visited_ff | cand_onehot;
               adj_raddr  = cand_vtx;
               if (depth_ff == LAST_DEPTH) begin
                  state_in = S_CHECK;
               end else begin
                  depth_in = depth_ff + ONE_C;
                  cand_in  = ONE_C;
                  state_in = S_LOAD;
               end
            end else begin
               cand_in = cand_inc;
            end
         end
         S_CHECK: begin
            // full path: needs the closing edge back to vertex 0
            if (adj_rdata[0]) begin
               emit_in  = '0;
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_POP1;
            end
         end
         S_POP1: begin
            stk_raddr = depth_ff[VW-1:0];
            state_in  = S_POP2;
         end
         S_POP2: begin
            // drop the vertex at this depth and resume after it
            visited_in = visited_ff & ~pop_onehot;
            cand_in    = stk_cand;
            stk_raddr  = depth_dec[VW-1:0];
            state_in   = S_POP3;
         end
         S_POP3: begin
            adj_raddr = stk_vertex;
            state_in  = S_LOAD;
         end
         S_EMIT_RD: begin
            // entries 0..N-1, then vertex 0 again to close the circuit
            if (out_free) begin
               stk_raddr = (emit_ff == N_C) ? '0 : emit_ff[VW-1:0];
               state_in  = S_EMIT_WR;
            end
         end
         S_EMIT_WR: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = out_vertex_ext[VERTEX_W-1:0];
            rsp_found_in  = 1'b1;
            rsp_last_in   = (emit_ff == N_C);
            if (emit_ff == N_C) begin
               state_in = S_IDLE;
            end else begin
               emit_in  = emit_ff + ONE_C;
               state_in = S_EMIT_RD;
            end
         end
         S_NONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = '0;
               rsp_found_in  = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         cand_ff      <= '0;
         visited_ff   <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         cand_ff      <= cand_in;
         visited_ff   <= visited_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.vertex = rsp_vertex_ff;
   assign rsp_bus.found  = rsp_found_ff;
   assign rsp_bus.last   = rsp_last_ff;

   // ---------------------------------------------------------------- stores
   hcs_adj_mem #(
      .ROWS   (NUM_VERTICES),
      .DATA_W (NUM_VERTICES),
      .ADDR_W (VW)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   hcs_stack_mem #(
      .DEPTH  (NUM_VERTICES),
      .DATA_W (SW),
      .ADDR_W (VW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // ---------------------------------------------------------------- checks
   // path length and visited set agree while a depth is being worked on
   `ASSERT_IMPLY(a_visited_matches_depth, clock, reset, state_ff == S_SCAN || state_ff == S_LOAD, $countones(visited_ff) == depth_ff)
   // the resume candidate stays within one past the last vertex
   `ASSERT_IMPLY(a_cand_range, clock, reset, state_ff == S_SCAN, cand_ff >= ONE_C && cand_ff <= N_C)
   // a pending non-final result only exists while the circuit is being sent
   `ASSERT_IMPLY(a_mid_result_in_emit, clock, reset, rsp_valid_ff && !rsp_last_ff, state_ff == S_EMIT_RD || state_ff == S_EMIT_WR)
   // a search never starts with the start vertex missing from the path
   `ASSERT_NEXT(a_init_marks_start, clock, reset, state_ff == S_INIT, visited_ff[0] && depth_ff == ONE_C)

endmodule

// ----- rtl/core/hcs_adj_mem.sv -----
// adjacency row store, one write and one registered read port
// rows read as zero until written; valid bits cleared by reset
module hcs_adj_mem #(
   parameter int unsigned ROWS   = 8,
   parameter int unsigned DATA_W = 8,
   parameter int unsigned ADDR_W = $clog2(ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [ROWS];
   logic [ROWS-1:0]   row_valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/core/hcs_stack_mem.sv -----
// path stack store: vertex and next candidate per search depth
// no dependencies; every entry is written before the search reads it
module hcs_stack_mem #(
   parameter int unsigned DEPTH  = 8,
   parameter int unsigned DATA_W = 8,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/hamiltonian_cycle_search_top_tb.sv -----
// testbench for the hamiltonian circuit search block: row loads, searches and checks
// every circuit transfer against a backtracking predictor kept in the bench
// depends on hcs_pkg, hcs_req_if, hcs_rsp_if and hamiltonian_cycle_search_top
`timescale 1ns / 1ps

module hamiltonian_cycle_search_top_tb;
   import hcs_pkg::*;

   localparam int unsigned NV             = DEFAULT_NUM_VERTICES;
   localparam int unsigned CLK_PERIOD_NS  = 12;
   localparam int unsigned RESET_CYCLES   = 10;
   localparam int unsigned TIMEOUT_CYCLES = 4_000_000;
   // cycles of quiet after the last circuit transfer before moving on
   localparam int unsigned DRAIN_SLACK    = 24;
   // rough cycle estimate above which a random search is thrown away
   localparam int unsigned SEARCH_BUDGET  = 2500;
   localparam int unsigned MAX_REPORTS    = 200;
   localparam int unsigned RANDOM_ROWS    = 420;
   localparam int unsigned LONG_HOLD      = 300;

   typedef logic [NV-1:0]                row_type;
   typedef logic [NV-1:0][NV-1:0]        adj_type;
   typedef logic [NV-1:0][VERTEX_W-1:0]  tour_type;
   typedef logic [VERTEX_W-1:0]          vtx_type;

   typedef struct packed {
      vtx_type vertex;
      logic    found;
      logic    last;
   } circuit_step_type;

   typedef enum {GRAPH_PLANTED, GRAPH_DENSE, GRAPH_SPARSE, GRAPH_MIRRORED} graph_style_type;
   typedef enum {RSP_ALWAYS, RSP_COIN, RSP_THREE_OF_FOUR, RSP_SPARSE} rsp_mode_type;

   logic clock;
   logic reset;

   hcs_req_if req_bus ();
   hcs_rsp_if rsp_bus ();

   hamiltonian_cycle_search_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // bench copy of the adjacency store, updated when a row transfer is accepted
   adj_type          adj_rows = '0;
   // circuit vertices still owed by the block, oldest first
   circuit_step_type steps_due [$];
   int unsigned      mismatch_count = 0;
   int unsigned      burst_left = 0;

   // long receiver hold-off: the test side flips hold_flip, the stall process counts
   bit              hold_flip = 1'b0;
   int unsigned     hold_len = 0;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD_NS / 2.0) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
      $display("FAILURE");
      $finish;
   end

   // depth-first search for the first circuit from vertex 0, candidates in
   // ascending order; cost is a rough cycle count used only to screen out costly searches
   function automatic bit find_first_circuit(input adj_type rows, output tour_type tour,
                                             output int unsigned cost);
      int unsigned next_try [NV];
      logic [NV-1:0] on_path;
      int unsigned lvl;
      int unsigned v;
      vtx_type prev;
      bit moved;
      cost = 0;
      tour = '0;
      foreach (next_try[i]) next_try[i] = 0;
      on_path = row_type'(1);
      lvl = 1;
      next_try[1] = 1;
      forever begin
         // full path: only the closing edge back to vertex 0 is left to test
         if (lvl >= NV) begin
            cost += 1;
            if (rows[tour[NV-1]][0]) return 1'b1;
            lvl = NV - 1;
            on_path[tour[lvl]] = 1'b0;
            cost += 4;
            continue;
         end
         v = next_try[lvl];
         prev = tour[lvl-1];
         moved = 1'b0;
         while (v < NV && !moved) begin
            cost += 1;
            if (rows[prev][v] && !on_path[v]) begin
               tour[lvl] = vtx_type'(v);
               next_try[lvl] = v + 1;
               on_path[v] = 1'b1;
               lvl++;
               if (lvl < NV) next_try[lvl] = 1;
               moved = 1'b1;
               cost += 1;
            end else begin
               v++;
            end
         end
         // candidates exhausted at this depth: step back one vertex
         if (!moved) begin
            next_try[lvl] = v;
            lvl--;
            if (lvl == 0) return 1'b0;
            on_path[tour[lvl]] = 1'b0;
            cost += 4;
         end
      end
   endfunction

   // store an accepted row; a final row also queues the circuit it must produce
   function automatic void absorb_row(input vtx_type idx, input row_type edges, input bit fin);
      tour_type tour;
      int unsigned cost;
      adj_rows[idx] = edges;
      if (!fin) return;
      if (find_first_circuit(adj_rows, tour, cost)) begin
         for (int k = 0; k < NV; k++) steps_due.push_back('{tour[k], 1'b1, 1'b0});
         steps_due.push_back('{tour[0], 1'b1, 1'b1});
      end else begin
         steps_due.push_back('{vtx_type'(0), 1'b0, 1'b1});
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // one row transfer; valid stays high after acceptance so the next row can
   // follow in the very next cycle, gaps come between bursts of random length
   task automatic send_row(input vtx_type idx, input row_type edges, input bit fin);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.row_index <= idx;
      req_bus.row_edges <= edges;
      req_bus.last_row  <= fin;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      absorb_row(idx, edges, fin);
   endtask

   // sender pauses until every owed circuit transfer has arrived
   task automatic wait_circuits_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (steps_due.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   function automatic row_type random_row(input int unsigned pct);
      row_type r;
      for (int b = 0; b < NV; b++) r[b] = ($urandom_range(0, 99) < pct);
      return r;
   endfunction

   // ---------------------------------------------------------------- directed

   // store is clear after reset, so the first search finds nothing
   task automatic test_empty_graph();
      send_row(vtx_type'(0), row_type'(0), 1'b1);
      wait_circuits_drained();
   endtask

   // every edge except those into vertex 0: the search walks every path and fails
   task automatic test_no_return_edge();
      for (int i = 0; i < NV; i++) send_row(vtx_type'(i), row_type'(8'hFE), i == NV - 1);
      wait_circuits_drained();
   endtask

   // complete graph with self loops: the circuit is the vertices in order
   task automatic test_complete_graph();
      for (int i = 0; i < NV; i++) send_row(vtx_type'(i), '1, i == NV - 1);
      wait_circuits_drained();
   endtask

   // rows stay stored across searches, one rewritten row changes the answer
   task automatic test_row_persistence();
      send_row(vtx_type'(0), row_type'(0), 1'b1);
      send_row(vtx_type'(0), row_type'(8'h80), 1'b1);
      wait_circuits_drained();
   endtask

   // receiver holds off while searches are offered back to back, so the
   // result side backs up and the request side has to stall
   task automatic test_result_backpressure();
      hold_len  <= LONG_HOLD;
      hold_flip <= ~hold_flip;
      send_row(vtx_type'(7), '1, 1'b1);
      send_row(vtx_type'(0), '1, 1'b1);
      send_row(vtx_type'(5), row_type'(8'h01), 1'b1);
      send_row(vtx_type'(5), '1, 1'b0);
      wait_circuits_drained();
   endtask

   // ------------------------------------------------------------------ random

   // a set of row writes closed by a final row; the graph is redrawn until its
   // search is cheap enough, up to eight draws, else an all-zero graph is sent
   task automatic send_graph_set(output int unsigned n);
      adj_type trial;
      tour_type tour;
      int unsigned cost;
      logic [NV-1:0] touched;
      graph_style_type style;
      int unsigned ring [NV];
      int unsigned order [NV];
      int unsigned cnt;
      int unsigned j;
      int unsigned tmp;
      bit fits;
      fits = 1'b0;
      for (int tries = 0; tries < 8 && !fits; tries++) begin
         trial = adj_rows;
         style = graph_style_type'($urandom_range(0, 3));
         touched = '1;
         case (style)
            GRAPH_PLANTED: begin
               // random hamiltonian ring through vertex 0 plus a few extra edges
               for (int i = 0; i < NV; i++) ring[i] = i;
               for (int i = NV - 1; i > 1; i--) begin
                  j = $urandom_range(1, i);
                  tmp = ring[i]; ring[i] = ring[j]; ring[j] = tmp;
               end
               for (int i = 0; i < NV; i++) trial[i] = random_row(15);
               for (int i = 0; i < NV; i++) trial[ring[i]][ring[(i + 1) % NV]] = 1'b1;
            end
            GRAPH_DENSE: begin
               if ($urandom_range(0, 9) >= 6) touched = row_type'($urandom_range(1, 2**NV - 1));
               for (int i = 0; i < NV; i++) if (touched[i]) trial[i] = random_row(70);
            end
            GRAPH_SPARSE: begin
               if ($urandom_range(0, 9) >= 6) touched = row_type'($urandom_range(1, 2**NV - 1));
               for (int i = 0; i < NV; i++) if (touched[i]) trial[i] = random_row(25);
            end
            default: begin
               // undirected graph: both directions of every chosen edge
               trial = '0;
               for (int a = 0; a < NV; a++)
                  for (int b = a; b < NV; b++)
                     if ($urandom_range(0, 1)) begin
                        trial[a][b] = 1'b1;
                        trial[b][a] = 1'b1;
                     end
            end
         endcase
         void'(find_first_circuit(trial, tour, cost));
         fits = (cost <= SEARCH_BUDGET);
      end
      if (!fits) begin
         trial = '0;
         touched = '1;
      end
      // rows go out in random order, the last one sent starts the search
      cnt = 0;
      for (int i = 0; i < NV; i++) if (touched[i]) order[cnt++] = i;
      for (int i = cnt - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      for (int i = 0; i < cnt; i++)
         send_row(vtx_type'(order[i]), trial[order[i]], i == cnt - 1);
      n = cnt;
   endtask

   // stray row with random content, sometimes a search on whatever is stored
   task automatic send_stray_row(output int unsigned n);
      adj_type trial;
      tour_type tour;
      int unsigned cost;
      vtx_type idx;
      row_type edges;
      bit fin;
      idx = vtx_type'($urandom_range(0, NV - 1));
      edges = row_type'($urandom_range(0, 2**NV - 1));
      fin = ($urandom_range(0, 9) < 4);
      if (fin) begin
         trial = adj_rows;
         trial[idx] = edges;
         void'(find_first_circuit(trial, tour, cost));
         if (cost > SEARCH_BUDGET) fin = 1'b0;
      end
      send_row(idx, edges, fin);
      n = 1;
   endtask

   task automatic test_random_graphs(input int unsigned target);
      int unsigned sent;
      int unsigned n;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 99) < 85) send_graph_set(n);
         else send_stray_row(n);
         sent += n;
         // now and then the sender waits for the block to go fully idle
         if ($urandom_range(0, 99) < 8) wait_circuits_drained();
      end
      wait_circuits_drained();
   endtask

   // ------------------------------------------------------- result side

   // receiver stalls on a randomly drawn pattern, redrawn when its run ends,
   // overridden by a long hold-off when the test side asks for one
   initial begin : rsp_stall_pattern
      rsp_mode_type mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned phase;
      bit hold_seen;
      mode = RSP_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      phase = 0;
      hold_seen = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_flip != hold_seen) begin
            hold_seen = hold_flip;
            hold_left = hold_len;
         end
         if (mode_left == 0) begin
            mode = rsp_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RSP_ALWAYS:        rsp_bus.ready <= 1'b1;
               RSP_COIN:          rsp_bus.ready <= 1'($urandom_range(0, 1));
               RSP_THREE_OF_FOUR: rsp_bus.ready <= (phase % 4) != 3;
               default:           rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // every accepted circuit transfer is matched against the oldest one owed
   always @(posedge clock) begin : circuit_check
      circuit_step_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (steps_due.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer vertex %0d found %b last %b",
                                      rsp_bus.vertex, rsp_bus.found, rsp_bus.last));
         end else begin
            want = steps_due.pop_front();
            if (rsp_bus.vertex !== want.vertex)
               report_mismatch($sformatf("vertex %0d, wanted %0d",
                                         rsp_bus.vertex, want.vertex));
            if (rsp_bus.found !== want.found)
               report_mismatch($sformatf("found %b, wanted %b", rsp_bus.found, want.found));
            if (rsp_bus.last !== want.last)
               report_mismatch($sformatf("last %b, wanted %b", rsp_bus.last, want.last));
         end
      end
   end

   // ------------------------------------------------------------ sequence

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.row_index <= '0;
      req_bus.row_edges <= '0;
      req_bus.last_row  <= 1'b0;
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_graph();
      test_no_return_edge();
      test_complete_graph();
      test_row_persistence();
      test_result_backpressure();
      test_random_graphs(RANDOM_ROWS);

      if (mismatch_count == 0 && steps_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
